// ----- rtl/byte_signature_scan_with_gap_assert.svh -----
// Assertion macros used by the signature scanner top level.
`ifndef BYTE_SIGNATURE_SCAN_WITH_GAP_ASSERT_SVH
`define BYTE_SIGNATURE_SCAN_WITH_GAP_ASSERT_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define BSIG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside of reset.
`define BSIG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bsig_pkg.sv -----
// Shared types and constants of the byte signature scanner.
package bsig_pkg;

    localparam int LITERAL_MAX_DEF = 16;
    localparam int GAP_BYTES_DEF   = 4;

    // Literal count and gap position registers are five bits wide.
    localparam int CNT_W     = 5;
    // Captured value is one 32-bit word, so at most four gap bytes land in it.
    localparam int CAP_LANES = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LITERALS_LOW  = 3'd0,
        REG_LITERALS_HIGH = 3'd1,
        REG_LITERAL_COUNT = 3'd2,
        REG_GAP_POSITION  = 3'd3,
        REG_IMAGE_BASE    = 3'd4
    } cfg_reg_t;

    // Pattern settings seen by every cell, already clamped to legal values.
    typedef struct packed {
        logic [CNT_W-1:0] lits;
        logic [CNT_W-1:0] gpos;
        logic [127:0]     literals;
    } cell_cfg_t;

    // What one cell reports about the byte it is about to hold.
    typedef struct packed {
        logic                 match;
        logic [CAP_LANES-1:0] cap_hot;
    } cell_stat_t;

endpackage

// ----- rtl/bsig_cell.sv -----
// One window cell: holds one byte and checks the byte shifting into it.
module bsig_cell #(
    parameter int INDEX     = 0,
    parameter int GAP_BYTES = bsig_pkg::GAP_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  logic [7:0]            byte_in,
    input  bsig_pkg::cell_cfg_t   cfg,
    output logic [7:0]            byte_out,
    output bsig_pkg::cell_stat_t  stat
);

    logic [7:0] byte_reg;
    logic [5:0] tot6;
    logic [5:0] gpos6;
    logic [5:0] pos6;
    logic [5:0] lit_pos6;
    logic       in_range;
    logic       is_gap;
    logic [3:0] lit_idx;
    logic [7:0] lit_byte;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // Position of this cell inside the signature, counted from its oldest byte.
    assign tot6     = {1'b0, cfg.lits} + 6'(GAP_BYTES);
    assign gpos6    = {1'b0, cfg.gpos};
    assign in_range = 6'(INDEX) < tot6;
    assign pos6     = tot6 - 6'd1 - 6'(INDEX);
    assign is_gap   = (pos6 >= gpos6) && (pos6 < gpos6 + 6'(GAP_BYTES));
    assign lit_pos6 = (pos6 < gpos6) ? pos6 : pos6 - 6'(GAP_BYTES);
    assign lit_idx  = lit_pos6[3:0];
    assign lit_byte = cfg.literals[{lit_idx, 3'b000} +: 8];

    assign stat.match = !in_range || is_gap || (byte_in == lit_byte);

    for (genvar l = 0; l < bsig_pkg::CAP_LANES; l++) begin : g_lane
        if (l < GAP_BYTES) begin : g_used
            assign stat.cap_hot[l] = in_range && (pos6 == gpos6 + 6'(l));
        end else begin : g_unused
            assign stat.cap_hot[l] = 1'b0;
        end
    end

endmodule

// ----- rtl/byte_signature_scan_with_gap.sv -----
// Top level of the byte signature scanner with one gap of unknown bytes.
//
// The scanner takes one image byte per item and searches the image for a
// signature of literal_count literal bytes with a gap of GAP_BYTES arbitrary
// bytes after the first gap_position literals. A row of LITERAL_MAX+GAP_BYTES
// cells forms the sliding byte window; each cell compares the byte shifting
// into it with the literal that belongs at its place, so a match is decided
// in the same cycle the last byte of the signature arrives. The block takes
// one item per clock cycle when the result side does not stall, and a result
// is registered onto the m_ channel in the cycle after the item that caused it. The
// path that sets the clock is the cell compare plus the AND across the row,
// next to the 32-bit address add. On the first match the block reports found,
// the absolute address of the first gap byte and up to four gap bytes as a
// little-endian word, then ignores bytes until the item flagged image_end.
// An image that ends without a match gives one item with found low and zero
// address and value. Configuration writes take effect for the next item and
// are always accepted; they are meant to happen only while the block is idle.
// A literal count of zero acts as one, counts above LITERAL_MAX saturate, and
// a gap position past the literals puts the gap at the end. The byte counter
// saturates at its maximum for huge images.
module byte_signature_scan_with_gap #(
    parameter int LITERAL_MAX = bsig_pkg::LITERAL_MAX_DEF,
    parameter int GAP_BYTES   = bsig_pkg::GAP_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_image_end,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [31:0]                   m_gap_address,
    output logic [31:0]                   m_captured_value,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsig_pkg::CFG_W-1:0]     cfg_data
);

    localparam int DEPTH = LITERAL_MAX + GAP_BYTES;

    // Configuration registers.
    logic [63:0]                 lit_low_reg;
    logic [63:0]                 lit_high_reg;
    logic [bsig_pkg::CNT_W-1:0]  lit_count_reg;
    logic [bsig_pkg::CNT_W-1:0]  gap_pos_reg;
    logic [31:0]                 image_base_reg;

    // Scan state.
    logic [31:0] seen_reg;
    logic [31:0] seen_next;
    logic        reported_reg;
    logic        reported_next;

    // Result register.
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        found_reg;
    logic [31:0] address_reg;
    logic [31:0] value_reg;

    logic                        accept;
    logic                        shift_en;
    logic                        produce;
    logic                        sat;
    logic                        enough;
    logic                        hit;
    logic [bsig_pkg::CNT_W-1:0]  lits_eff;
    logic [bsig_pkg::CNT_W-1:0]  gpos_eff;
    logic [5:0]                  tot6;
    logic signed [6:0]           delta7;
    logic [31:0]                 hit_address;
    logic [31:0]                 hit_value;
    bsig_pkg::cell_cfg_t         cell_cfg;

    logic [7:0]           cell_in  [DEPTH];
    logic [7:0]           cell_out [DEPTH];
    bsig_pkg::cell_stat_t cell_stat[DEPTH];
    logic [DEPTH-1:0]     cell_match;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_low_reg    <= '0;
            lit_high_reg   <= '0;
            lit_count_reg  <= bsig_pkg::CNT_W'(1);
            gap_pos_reg    <= '0;
            image_base_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bsig_pkg::REG_LITERALS_LOW:  lit_low_reg    <= cfg_data;
                bsig_pkg::REG_LITERALS_HIGH: lit_high_reg   <= cfg_data;
                bsig_pkg::REG_LITERAL_COUNT: lit_count_reg  <= cfg_data[bsig_pkg::CNT_W-1:0];
                bsig_pkg::REG_GAP_POSITION:  gap_pos_reg    <= cfg_data[bsig_pkg::CNT_W-1:0];
                bsig_pkg::REG_IMAGE_BASE:    image_base_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Clamp the pattern shape to what the window can hold.
    always_comb begin
        if (lit_count_reg == '0) begin
            lits_eff = bsig_pkg::CNT_W'(1);
        end else if (lit_count_reg > bsig_pkg::CNT_W'(LITERAL_MAX)) begin
            lits_eff = bsig_pkg::CNT_W'(LITERAL_MAX);
        end else begin
            lits_eff = lit_count_reg;
        end
        gpos_eff = (gap_pos_reg > lits_eff) ? lits_eff : gap_pos_reg;
    end

    assign tot6              = {1'b0, lits_eff} + 6'(GAP_BYTES);
    assign cell_cfg.lits     = lits_eff;
    assign cell_cfg.gpos     = gpos_eff;
    assign cell_cfg.literals = {lit_high_reg, lit_low_reg};

    // The result register frees up in the same cycle it is taken, and every
    // item yields at most one result, so input stalls only while a result waits untaken.
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign shift_en = accept && !reported_reg;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign cell_in[k] = s_data_byte;
        end else begin : g_body
            assign cell_in[k] = cell_out[k-1];
        end

        bsig_cell #(
            .INDEX     (k),
            .GAP_BYTES (GAP_BYTES)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .byte_in  (cell_in[k]),
            .cfg      (cell_cfg),
            .byte_out (cell_out[k]),
            .stat     (cell_stat[k])
        );

        assign cell_match[k] = cell_stat[k].match;
    end

    // Gap bytes are gathered from the cells flagged for each byte lane.
    always_comb begin
        hit_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            for (int l = 0; l < bsig_pkg::CAP_LANES; l++) begin
                if (cell_stat[k].cap_hot[l]) begin
                    hit_value[l*8 +: 8] = hit_value[l*8 +: 8] | cell_in[k];
                end
            end
        end
    end

    // The match needs the whole signature to have arrived, counting this byte.
    assign sat    = (seen_reg == '1);
    assign enough = sat || (seen_reg >= ({26'b0, tot6} - 32'd1));
    assign hit    = enough && (&cell_match);

    // Gap offset is the updated count minus the signature length plus the gap
    // position; the small signed part folds the increment in.
    assign delta7 = $signed({2'b00, gpos_eff}) + $signed({6'b0, !sat})
                  - $signed({1'b0, tot6});
    assign hit_address = image_base_reg + seen_reg + 32'(delta7);

    always_comb begin
        seen_next     = seen_reg;
        reported_next = reported_reg;
        produce       = 1'b0;
        if (accept) begin
            if (reported_reg) begin
                if (s_image_end) begin
                    seen_next     = '0;
                    reported_next = 1'b0;
                end
            end else begin
                seen_next = sat ? seen_reg : seen_reg + 32'd1;
                produce   = hit || s_image_end;
                if (s_image_end) begin
                    seen_next     = '0;
                    reported_next = 1'b0;
                end else if (hit) begin
                    reported_next = 1'b1;
                end
            end
        end
        if (produce) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            reported_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            found_reg   <= hit;
            address_reg <= hit ? hit_address : '0;
            value_reg   <= hit ? hit_value : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_found          = found_reg;
    assign m_gap_address    = address_reg;
    assign m_captured_value = value_reg;

`include "byte_signature_scan_with_gap_assert.svh"

    // Once a match is reported, only the image end may release the scanner.
    `BSIG_ASSERT_NEXT(a_reported_holds, accept && reported_reg && !s_image_end, reported_reg, "match flag dropped before image end")
    // The image end always starts a fresh image.
    `BSIG_ASSERT_NEXT(a_end_clears, accept && s_image_end, (seen_reg == '0) && !reported_reg, "image end did not clear scan state")
    // A not-found result carries zero address and value.
    `BSIG_ASSERT_NOW(a_miss_zero, m_valid_reg && !found_reg, (address_reg == '0) && (value_reg == '0), "not-found result with nonzero payload")
    // Gap lane 0 is fed by at most one of the first three cells.
    `BSIG_ASSERT_NOW(a_lane_unique, shift_en, $onehot0({cell_stat[0].cap_hot[0], cell_stat[1].cap_hot[0], cell_stat[2].cap_hot[0]}), "gap lane selected by several cells")

endmodule
